// ===== design/jfb64_pkg.sv =====
// ----------------------------------------------------------------------------
// jfb64_pkg
// shared types, character codes and the base64 sextet lookup for the
// json field base64 stream extractor
// ----------------------------------------------------------------------------
`default_nettype none

package jfb64_pkg;

	// decoded bytes per chunk
	localparam int unsigned CHUNK_BYTES = 4096;
	localparam int unsigned CNT_W       = $clog2(CHUNK_BYTES + 1);

	localparam int unsigned HIST_LEN = 10;
	localparam int unsigned MAX_RES  = 3;
	localparam int unsigned RES_W    = $clog2(MAX_RES + 1);
	localparam int unsigned GRP_LEN  = 3;

	// character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5a;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;

	// key texts, first character in the top byte
	localparam logic [63:0] KEY_SHORT = "\"data\":\"";
	localparam logic [79:0] KEY_LONG  = "\"data\" : \"";

	typedef enum logic [1:0] {
		RK_BYTE   = 2'd0,
		RK_END_OK = 2'd1,
		RK_ERROR  = 2'd2
	} rkind_t;

	typedef enum logic [1:0] {
		EC_NONE       = 2'd0,
		EC_BAD_ESC    = 2'd1,
		EC_BAD_CHAR   = 2'd2,
		EC_INCOMPLETE = 2'd3
	} err_t;

	typedef struct packed {
		rkind_t     result_kind;
		logic [7:0] out_byte;
		logic       chunk_last;
		err_t       error_code;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	// base64 character to six-bit value; '=' maps to zero
	function automatic sextet_t sextet(input logic [7:0] ch);
		sextet_t s;
		s.ok    = 1'b1;
		s.value = 6'd0;
		if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			s.value = 6'(ch - CH_UP_A);
		end else if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
			s.value = 6'(ch - CH_LOW_A + 8'd26);
		end else if (ch >= CH_DIG_0 && ch <= CH_DIG_9) begin
			s.value = 6'(ch - CH_DIG_0 + 8'd52);
		end else if (ch == CH_PLUS) begin
			s.value = 6'd62;
		end else if (ch == CH_SLASH) begin
			s.value = 6'd63;
		end else if (ch == CH_EQ) begin
			s.value = 6'd0;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

	function automatic result_t make_res(input rkind_t rk, input logic [7:0] b,
		input logic cl, input err_t ec, input logic last);
		result_t r;
		r.result_kind = rk;
		r.out_byte    = b;
		r.chunk_last  = cl;
		r.error_code  = ec;
		r.run_last    = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/jfb64_if.sv =====
// ----------------------------------------------------------------------------
// jfb64 channel interfaces
// valid/ready channels for body bytes in and decoded results out
// ----------------------------------------------------------------------------
`default_nettype none

interface jfb64_body_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source(output valid, output kind, output in_byte, input ready);
	modport sink(input valid, input kind, input in_byte, output ready);
endinterface

interface jfb64_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] out_byte;
	logic       chunk_last;
	logic [1:0] error_code;
	logic       run_last;

	modport source(output valid, output result_kind, output out_byte, output chunk_last,
		output error_code, output run_last, input ready);
	modport sink(input valid, input result_kind, input out_byte, input chunk_last,
		input error_code, input run_last, output ready);
endinterface

`default_nettype wire

// ===== design/json_field_base64_stream_extractor_core.sv =====
// a request accepted into the input register is decoded into the result register when
//   the bundle register is free, and its first result is then offered from there
// throughput: one request per cycle while results are taken; a closing base64 group
//   yields up to three bytes that drain one per ready cycle, holding the input meanwhile
// reset: arst_n clears the key history, field flags, group count, chunk count and
//   error state at once; the collected group characters are not reset
// ----------------------------------------------------------------------------
// json_field_base64_stream_extractor_core
// finds the "data" key in a response body, unescapes the string value and
// decodes its base64 characters into a byte stream with chunk marks
// ----------------------------------------------------------------------------
`default_nettype none

module json_field_base64_stream_extractor_core (
	input  logic             clk,
	input  logic             arst_n,
	jfb64_body_if.sink       body,
	jfb64_result_if.source   result
);
	import jfb64_pkg::*;

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// extractor state
	logic [HIST_LEN*8-1:0] hist_q, hist_d;
	logic                  in_field_q, in_field_d;
	logic                  field_done_q, field_done_d;
	logic                  esc_q, esc_d;
	logic [7:0]            gchar_q [GRP_LEN];
	logic [7:0]            gchar_d [GRP_LEN];
	logic [1:0]            gcount_q, gcount_d;
	logic [CNT_W-1:0]      chunk_q, chunk_d;
	err_t                  sticky_q, sticky_d;

	// result bundle: up to three results of one request, drained in order
	result_t          res_q [MAX_RES];
	result_t          res_d [MAX_RES];
	logic [RES_W-1:0] n_q, n_d;
	logic [RES_W-1:0] idx_q;

	logic    out_fire;
	logic    drain_last;
	logic    bundle_free;
	logic    adv;
	logic    in_fire;
	result_t cur;

	// ------------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------------
	assign cur         = res_q[idx_q[1:0]];
	assign out_fire    = result.valid && result.ready;
	assign drain_last  = out_fire && (idx_q == n_q - RES_W'(1));
	// the bundle register can take the next request's results
	assign bundle_free = (n_q == '0) || drain_last;
	assign adv         = valid_s1 && bundle_free;
	assign body.ready  = !valid_s1 || adv;
	assign in_fire     = body.valid && body.ready;

	assign result.valid       = (n_q != '0);
	assign result.result_kind = cur.result_kind;
	assign result.out_byte    = cur.out_byte;
	assign result.chunk_last  = cur.chunk_last;
	assign result.error_code  = cur.error_code;
	assign result.run_last    = cur.run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1 <= body.kind;
			byte_s1 <= body.in_byte;
		end
	end

	// ------------------------------------------------------------------------
	// request processing
	// ------------------------------------------------------------------------
	logic             as_char;
	logic             is_ws;
	logic             key_hit;
	sextet_t          sx;
	sextet_t          sx0, sx1, sx2;
	logic [23:0]      word;
	logic [1:0]       nbytes;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] cnt_inc;
	logic             cl;
	err_t             end_code;

	always_comb begin
		hist_d       = hist_q;
		in_field_d   = in_field_q;
		field_done_d = field_done_q;
		esc_d        = esc_q;
		gchar_d      = gchar_q;
		gcount_d     = gcount_q;
		chunk_d      = chunk_q;
		sticky_d     = sticky_q;
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = make_res(RK_BYTE, 8'h00, 1'b0, EC_NONE, 1'b0);
		end
		n_d      = '0;
		as_char  = 1'b0;
		key_hit  = 1'b0;
		end_code = sticky_q;
		cnt      = chunk_q;
		cnt_inc  = '0;
		cl       = 1'b0;
		sx       = sextet(byte_s1);
		sx0      = sextet(gchar_q[0]);
		sx1      = sextet(gchar_q[1]);
		sx2      = sextet(gchar_q[2]);
		word     = {sx0.value, sx1.value, sx2.value, sx.value};
		nbytes   = (gchar_q[2] == CH_EQ) ? 2'd1 : (byte_s1 == CH_EQ) ? 2'd2 : 2'd3;
		is_ws    = (byte_s1 == CH_CR) || (byte_s1 == CH_LF) ||
			(byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB);

		if (kind_s1) begin
			// end of response: report and return to reset
			if (sticky_q == EC_NONE && (gcount_q != 2'd0 || in_field_q || !field_done_q)) begin
				end_code = EC_INCOMPLETE;
			end
			res_d[0] = make_res((end_code != EC_NONE) ? RK_ERROR : RK_END_OK, 8'h00, 1'b0,
				end_code, 1'b1);
			n_d          = RES_W'(1);
			hist_d       = '0;
			in_field_d   = 1'b0;
			field_done_d = 1'b0;
			esc_d        = 1'b0;
			gcount_d     = 2'd0;
			chunk_d      = '0;
			sticky_d     = EC_NONE;
		end else if (sticky_q == EC_NONE && !field_done_q) begin
			if (!in_field_q) begin
				// key search over the newest ten bytes
				hist_d  = {hist_q[HIST_LEN*8-9:0], byte_s1};
				key_hit = (hist_d[63:0] == KEY_SHORT) || (hist_d == KEY_LONG);
				if (key_hit) begin
					in_field_d = 1'b1;
				end
			end else if (esc_q) begin
				esc_d = 1'b0;
				if (byte_s1 == CH_LOW_N || byte_s1 == CH_LOW_R || byte_s1 == CH_LOW_T) begin
					as_char = 1'b0;
				end else if (byte_s1 != CH_SLASH) begin
					sticky_d = EC_BAD_ESC;
					res_d[0] = make_res(RK_ERROR, 8'h00, 1'b0, EC_BAD_ESC, 1'b1);
					n_d      = RES_W'(1);
				end else begin
					// escaped slash counts as a base64 character
					as_char = 1'b1;
				end
			end else if (byte_s1 == CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (byte_s1 == CH_QUOTE) begin
				in_field_d   = 1'b0;
				field_done_d = 1'b1;
			end else begin
				as_char = 1'b1;
			end

			if (as_char && !is_ws) begin
				if (!sx.ok || (byte_s1 == CH_EQ && gcount_q < 2'd2) ||
					(gcount_q == 2'd3 && gchar_q[2] == CH_EQ && byte_s1 != CH_EQ)) begin
					// bad character or misplaced padding
					sticky_d = EC_BAD_CHAR;
					res_d[0] = make_res(RK_ERROR, 8'h00, 1'b0, EC_BAD_CHAR, 1'b1);
					n_d      = RES_W'(1);
				end else if (gcount_q < 2'd3) begin
					gchar_d[gcount_q] = byte_s1;
					gcount_d          = gcount_q + 2'd1;
				end else begin
					// group complete: emit its bytes with chunk marks
					gcount_d = 2'd0;
					n_d      = RES_W'(nbytes);
					for (int i = 0; i < MAX_RES; i++) begin
						if (2'(i) < nbytes) begin
							cnt_inc = cnt + CNT_W'(1);
							cl      = (cnt_inc >= CNT_W'(CHUNK_BYTES));
							cnt     = cl ? '0 : cnt_inc;
							res_d[i] = make_res(RK_BYTE, word[8*(MAX_RES-1-i) +: 8], cl,
								EC_NONE, (2'(i) == nbytes - 2'd1));
						end
					end
					chunk_d = cnt;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// state and result registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q       <= '0;
			in_field_q   <= 1'b0;
			field_done_q <= 1'b0;
			esc_q        <= 1'b0;
			gcount_q     <= 2'd0;
			chunk_q      <= '0;
			sticky_q     <= EC_NONE;
		end else if (adv) begin
			hist_q       <= hist_d;
			in_field_q   <= in_field_d;
			field_done_q <= field_done_d;
			esc_q        <= esc_d;
			gcount_q     <= gcount_d;
			chunk_q      <= chunk_d;
			sticky_q     <= sticky_d;
		end
	end

	// group characters carry no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			gchar_q <= gchar_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			idx_q <= '0;
		end else if (adv) begin
			n_q   <= n_d;
			idx_q <= '0;
		end else if (drain_last) begin
			n_q   <= '0;
			idx_q <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + RES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
`ifndef SYNTH
	// drain index stays inside the bundle
	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (idx_q < n_q))
		else $error("result index beyond bundle");

	// an end request leaves clean state and exactly one result
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1) |=> (!in_field_q && !field_done_q && gcount_q == 2'd0 &&
			sticky_q == EC_NONE && n_q == RES_W'(1)))
		else $error("end request did not clear state");

	// body bytes after an error produce nothing
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !kind_s1 && sticky_q != EC_NONE) |=> (n_q == '0))
		else $error("result after sticky error");
`endif

endmodule

`default_nettype wire
